// ===== rtl/ipsl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipsl_pkg
// Shared types and constants of the incremental PI speed loop.
// ----------------------------------------------------------------------------
package ipsl_pkg;

    // Pipeline depth: input register, five datapath stages, result register.
    localparam int STAGES = 7;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_INTEGRAL_GAIN      = 3'd0,
        REG_PROPORTIONAL_GAIN  = 3'd1,
        REG_TURN_SLOWDOWN_GAIN = 3'd2,
        REG_MIN_SPEED          = 3'd3,
        REG_MAX_SPEED          = 3'd4,
        REG_PWM_MAX            = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic        [15:0] integral_gain;
        logic        [15:0] proportional_gain;
        logic        [15:0] turn_slowdown_gain;
        logic signed [15:0] min_speed;
        logic signed [15:0] max_speed;
        logic        [15:0] pwm_max;
    } cfg_t;

    // Load enables, one per pipeline register stage.
    typedef struct packed {
        logic in_ld;
        logic prod_ld;
        logic red_ld;
        logic err_ld;
        logic num_ld;
        logic term_ld;
        logic out_ld;
    } stage_ld_t;

    // floor(x / 125) = (x * RECIP_125) >> 27, exact for x < 2**20.
    localparam logic [20:0] RECIP_125 = 21'd1073742;
    // floor(x / 5) = (x * RECIP_5) >> 26, exact for x < 2**24.
    localparam logic [23:0] RECIP_5 = 24'd13421773;

endpackage

// ===== rtl/incremental_pi_speed_loop_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_pi_speed_loop_unit
// Incremental PI speed loop with turn slowdown of the target speed.
// ----------------------------------------------------------------------------
//
//  channel  handshake              payload
//  -------  ---------------------  ------------------------------------------
//  in       in_valid / in_stall    target_speed, measured_speed, track_error
//  out      out_valid / out_stall  pwm_drive, adjusted_target
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One item per cycle sustained while out does not stall; each item reaches
//  the result register via the input register and five datapath stages.
//  The loops between items, the error history in stage 3 and the drive
//  accumulator add and clamp in the last stage, each close within one
//  stage, so back-to-back items never wait on them.
//  Reset clears valid bits, configuration, error history and drive.
//  A stall on out only holds the stages that are full behind it; empty
//  stages keep filling, so in_stall rises only when the whole pipe is full.
//
// Stage map:
//   0  input register
//   1  |track_error| * turn_slowdown_gain
//   2  reduction via reciprocal of 125
//   3  clamp target, speed error, error difference
//   4  integral and proportional products summed
//   5  magnitude / 2560 via reciprocal of 5
//   6  drive accumulate and clamp (result register)
// ----------------------------------------------------------------------------
module incremental_pi_speed_loop_unit
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  target_speed,
    input  logic signed [15:0]  measured_speed,
    input  logic signed [15:0]  track_error,

    output logic                out_valid,
    input  logic                out_stall,
    output logic        [15:0]  pwm_drive,
    output logic signed [15:0]  adjusted_target,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam int LAST = ipsl_pkg::STAGES - 1;

    logic [LAST:0]          valid_reg;
    logic [LAST:0]          ready;
    logic [LAST:0]          load;
    ipsl_pkg::stage_ld_t    ld;
    ipsl_pkg::cfg_t         cfg;
    logic signed [15:0]     err;
    logic signed [16:0]     diff;
    logic signed [15:0]     adj;

    // A stage takes a new item when it is empty or its content moves on.
    always_comb
    begin
        ready[LAST] = !valid_reg[LAST] || !out_stall;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i + 1];
        end
        load[0] = ready[0] && in_valid;
        for (int i = 1; i <= LAST; i++)
        begin
            load[i] = ready[i] && valid_reg[i - 1];
        end
    end

    // Advance valid bits; hold a stage whose successor is full and stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg[0] <= ready[0] ? in_valid : valid_reg[0];
            for (int i = 1; i <= LAST; i++)
            begin
                valid_reg[i] <= ready[i] ? valid_reg[i - 1] : valid_reg[i];
            end
        end
    end

    // Map each stage's load to its named enable, input stage first.
    assign ld.in_ld   = load[0];
    assign ld.prod_ld = load[1];
    assign ld.red_ld  = load[2];
    assign ld.err_ld  = load[3];
    assign ld.num_ld  = load[4];
    assign ld.term_ld = load[5];
    assign ld.out_ld  = load[6];

    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[LAST];

    ipsl_cfg_regs u_cfg_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg)
    );

    ipsl_speed_err u_speed_err
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ld             (ld),
        .cfg            (cfg),
        .target_speed   (target_speed),
        .measured_speed (measured_speed),
        .track_error    (track_error),
        .err            (err),
        .diff           (diff),
        .adj            (adj)
    );

    ipsl_pi_update u_pi_update
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .ld              (ld),
        .cfg             (cfg),
        .err             (err),
        .diff            (diff),
        .adj             (adj),
        .pwm_drive       (pwm_drive),
        .adjusted_target (adjusted_target)
    );

endmodule

// ===== rtl/ipsl_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipsl_cfg_regs
// Configuration register file; writes beyond the register list are dropped.
// ----------------------------------------------------------------------------
module ipsl_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output ipsl_pkg::cfg_t      cfg
);

    ipsl_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ipsl_pkg::REG_INTEGRAL_GAIN:      cfg_reg.integral_gain      <= cfg_data;
                ipsl_pkg::REG_PROPORTIONAL_GAIN:  cfg_reg.proportional_gain  <= cfg_data;
                ipsl_pkg::REG_TURN_SLOWDOWN_GAIN: cfg_reg.turn_slowdown_gain <= cfg_data;
                ipsl_pkg::REG_MIN_SPEED:          cfg_reg.min_speed          <= cfg_data;
                ipsl_pkg::REG_MAX_SPEED:          cfg_reg.max_speed          <= cfg_data;
                ipsl_pkg::REG_PWM_MAX:            cfg_reg.pwm_max            <= cfg_data;
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

endmodule

// ===== rtl/ipsl_speed_err.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipsl_speed_err
// Input register, turn slowdown, target clamp, speed error and its difference.
// ----------------------------------------------------------------------------
module ipsl_speed_err
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ipsl_pkg::stage_ld_t     ld,
    input  ipsl_pkg::cfg_t          cfg,
    input  logic signed [15:0]      target_speed,
    input  logic signed [15:0]      measured_speed,
    input  logic signed [15:0]      track_error,
    output logic signed [15:0]      err,
    output logic signed [16:0]      diff,
    output logic signed [15:0]      adj
);

    // Input register
    logic signed [15:0] tgt0_reg;
    logic signed [15:0] meas0_reg;
    logic signed [15:0] trk0_reg;

    // Slowdown product
    logic        [15:0] mag;
    logic        [31:0] prod1_next;
    logic        [31:0] prod1_reg;
    logic signed [15:0] tgt1_reg;
    logic signed [15:0] meas1_reg;

    // Reduction = product / 256000
    logic        [40:0] recip_prod;
    logic        [13:0] red_next;
    logic        [13:0] red_reg;
    logic signed [15:0] tgt2_reg;
    logic signed [15:0] meas2_reg;

    // Clamp and error
    logic signed [17:0] adj_wide;
    logic signed [17:0] min_w;
    logic signed [17:0] max_w;
    logic signed [17:0] lim_lo;
    logic signed [17:0] lim;
    logic signed [15:0] adj_next;
    logic signed [15:0] err_next;
    logic signed [16:0] diff_next;
    logic signed [15:0] err_reg;
    logic signed [16:0] diff_reg;
    logic signed [15:0] adj_reg;
    logic signed [15:0] prev_err_reg;

    always_ff @(posedge clk)
    begin
        if (ld.in_ld)
        begin
            tgt0_reg  <= target_speed;
            meas0_reg <= measured_speed;
            trk0_reg  <= track_error;
        end
    end

    // Two's complement negate gives 0x8000 for the most negative error,
    // which read as unsigned is the right magnitude.
    assign mag        = trk0_reg[15] ? 16'(~trk0_reg + 16'sd1) : 16'(trk0_reg);
    assign prod1_next = cfg.turn_slowdown_gain * mag;

    always_ff @(posedge clk)
    begin
        if (ld.prod_ld)
        begin
            prod1_reg <= prod1_next;
            tgt1_reg  <= tgt0_reg;
            meas1_reg <= meas0_reg;
        end
    end

    // 256000 = 2048 * 125: drop 11 bits, then divide by 125 by reciprocal.
    // The product stays below 2**31, so bits 30:11 carry the quotient input.
    assign recip_prod = prod1_reg[30:11] * ipsl_pkg::RECIP_125;
    assign red_next   = recip_prod[40:27];

    always_ff @(posedge clk)
    begin
        if (ld.red_ld)
        begin
            red_reg   <= red_next;
            tgt2_reg  <= tgt1_reg;
            meas2_reg <= meas1_reg;
        end
    end

    // Raise to min, then lower to max: crossed limits give max.
    always_comb
    begin
        adj_wide  = {{2{tgt2_reg[15]}}, tgt2_reg} - {4'b0000, red_reg};
        min_w     = {{2{cfg.min_speed[15]}}, cfg.min_speed};
        max_w     = {{2{cfg.max_speed[15]}}, cfg.max_speed};
        lim_lo    = (adj_wide < min_w) ? min_w : adj_wide;
        lim       = (lim_lo > max_w) ? max_w : lim_lo;
        adj_next  = lim[15:0];
        err_next  = adj_next - meas2_reg;
        diff_next = {err_next[15], err_next} - {prev_err_reg[15], prev_err_reg};
    end

    always_ff @(posedge clk)
    begin
        if (ld.err_ld)
        begin
            err_reg  <= err_next;
            diff_reg <= diff_next;
            adj_reg  <= adj_next;
        end
    end

    // Error history advances once per item, in item order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
        end
        else if (ld.err_ld)
        begin
            prev_err_reg <= err_next;
        end
    end

    assign err  = err_reg;
    assign diff = diff_reg;
    assign adj  = adj_reg;

endmodule

// ===== rtl/ipsl_pi_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipsl_pi_update
// Incremental PI term, division by 2560 and the clamped drive accumulator.
// ----------------------------------------------------------------------------
module ipsl_pi_update
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ipsl_pkg::stage_ld_t     ld,
    input  ipsl_pkg::cfg_t          cfg,
    input  logic signed [15:0]      err,
    input  logic signed [16:0]      diff,
    input  logic signed [15:0]      adj,
    output logic        [15:0]      pwm_drive,
    output logic signed [15:0]      adjusted_target
);

    // Weighted sum
    logic signed [32:0] prod_i;
    logic signed [33:0] prod_p;
    logic signed [34:0] num_next;
    logic signed [34:0] num_reg;
    logic signed [15:0] adj4_reg;

    // Truncating division by 2560
    logic signed [34:0] num_abs;
    logic        [47:0] quot_prod;
    logic        [21:0] q_next;
    logic        [21:0] q_reg;
    logic               neg_reg;
    logic signed [15:0] adj5_reg;

    // Accumulate and clamp
    logic        [24:0] q_ext;
    logic        [24:0] term;
    logic        [24:0] sum;
    logic        [15:0] drive_next;
    logic        [15:0] pwm_drive_reg;
    logic signed [15:0] adj_out_reg;

    always_comb
    begin
        prod_i   = $signed({1'b0, cfg.integral_gain}) * err;
        prod_p   = $signed({1'b0, cfg.proportional_gain}) * diff;
        num_next = {{2{prod_i[32]}}, prod_i} + {prod_p[33], prod_p};
    end

    always_ff @(posedge clk)
    begin
        if (ld.num_ld)
        begin
            num_reg  <= num_next;
            adj4_reg <= adj;
        end
    end

    // 2560 = 512 * 5. Divide the magnitude and restore the sign later,
    // which truncates toward zero. The magnitude stays below 2**33.
    always_comb
    begin
        num_abs   = num_reg[34] ? -num_reg : num_reg;
        quot_prod = num_abs[32:9] * ipsl_pkg::RECIP_5;
        q_next    = quot_prod[47:26];
    end

    always_ff @(posedge clk)
    begin
        if (ld.term_ld)
        begin
            q_reg    <= q_next;
            neg_reg  <= num_reg[34];
            adj5_reg <= adj4_reg;
        end
    end

    always_comb
    begin
        q_ext = {3'b000, q_reg};
        term  = neg_reg ? (~q_ext + 25'd1) : q_ext;
        sum   = term + {9'b0_0000_0000, pwm_drive_reg};
        if (sum[24])
        begin
            drive_next = '0;
        end
        else if (sum > {9'b0_0000_0000, cfg.pwm_max})
        begin
            drive_next = cfg.pwm_max;
        end
        else
        begin
            drive_next = sum[15:0];
        end
    end

    // The result register doubles as the drive accumulator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_drive_reg <= '0;
        end
        else if (ld.out_ld)
        begin
            pwm_drive_reg <= drive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.out_ld)
        begin
            adj_out_reg <= adj5_reg;
        end
    end

    assign pwm_drive       = pwm_drive_reg;
    assign adjusted_target = adj_out_reg;

endmodule

// ===== rtl/ipsl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipsl_checker
// Port-level checks of the speed loop unit, bound to the top level.
// ----------------------------------------------------------------------------
module ipsl_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_stall,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic        [15:0]  pwm_drive,
    input  logic signed [15:0]  adjusted_target,
    input  logic                cfg_ready
);

    // Reset empties the result slot by the next edge.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid high after reset");

    // With the result slot empty the pipe can always move, so input flows.
    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("in_stall while output is empty");

    // A stalled result holds its value and stays valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pwm_drive)
            && $stable(adjusted_target))
        else $error("stalled result changed");

    // The configuration port never back-pressures.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("cfg_ready low");

endmodule

bind incremental_pi_speed_loop_unit ipsl_checker u_ipsl_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .pwm_drive       (pwm_drive),
    .adjusted_target (adjusted_target),
    .cfg_ready       (cfg_ready)
);
